// File: rtl/bdcm_pkg.sv
// Shared constants and types for the button debounce and configuration mode block.
package bdcm_pkg;

    localparam int NUM_CH       = 13;
    localparam int PANEL_W      = 10;
    localparam int CH_TEST      = 10;
    localparam int CH_SERVICE   = 11;
    localparam int CH_MODE      = 12;
    localparam int CNT_W        = 16;
    localparam int THR_W        = 16;
    localparam int MODE_W       = 4;
    localparam int TIME_W       = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int MODE_COUNT   = 7;
    localparam int CHANNELS_DEF = 13;

    localparam logic [CFG_IDX_W-1:0] REG_DEB_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEB_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_MODE    = 2'd3;

    localparam logic [CNT_W-1:0]  RST_DEB_SAMPLES = 16'd8;
    localparam logic [THR_W-1:0]  RST_HOLD_THR    = 16'd3000;

    // Control handed to the debouncer bank for one transaction.
    typedef struct packed {
        logic             step;
        logic [CNT_W-1:0] need;
    } deb_ctrl_t;

endpackage

// File: rtl/bdcm_sample_if.sv
// Input channel: raw button levels and timestamp with a valid/ready handshake.
interface bdcm_sample_if;
    import bdcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [PANEL_W-1:0] raw_panels;
    logic               test_button;
    logic               service_button;
    logic               raw_mode_button;
    logic [TIME_W-1:0]  now_ms;

    modport source (
        output valid, raw_panels, test_button, service_button, raw_mode_button, now_ms,
        input  ready
    );
    modport sink (
        input  valid, raw_panels, test_button, service_button, raw_mode_button, now_ms,
        output ready
    );
endinterface

// File: rtl/bdcm_report_if.sv
// Output channel: qualified levels and configuration mode status.
interface bdcm_report_if;
    import bdcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [PANEL_W-1:0] panel_levels;
    logic               test_level;
    logic               service_level;
    logic               mode_level;
    logic               config_active;
    logic [MODE_W-1:0]  selected_mode;
    logic               save_request;

    modport source (
        output valid, panel_levels, test_level, service_level, mode_level,
               config_active, selected_mode, save_request,
        input  ready
    );
    modport sink (
        input  valid, panel_levels, test_level, service_level, mode_level,
               config_active, selected_mode, save_request,
        output ready
    );
endinterface

// File: rtl/button_debounce_config_mode_core.sv
// Top level of the button debounce and configuration mode block.
// The block takes one sample transaction per clock while the output is not stalled and returns
// one report transaction per sample: the sample is captured in an input register, all thirteen
// channels are debounced in parallel together with the hold timer and mode selection logic, and
// the result lands in an output register. The input stays ready whenever the output register is
// empty or being emptied in the same cycle. Configuration writes take effect on the next
// clock edge.
module button_debounce_config_mode_core #(
    parameter int CHANNELS = bdcm_pkg::CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bdcm_sample_if.sink                        sample,
    bdcm_report_if.source                      report,
    input  logic                               wr_en,
    input  logic [bdcm_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [bdcm_pkg::CFG_DATA_W-1:0]    wr_data
);
    import bdcm_pkg::*;

    localparam int DEB_CH     = (CHANNELS < NUM_CH) ? CHANNELS : NUM_CH;
    localparam int WRAP_STEPS = (1 << MODE_W) / MODE_COUNT;
    localparam logic [MODE_W:0] MODE_LIM = MODE_COUNT[MODE_W:0];

    // Configuration registers.
    logic              deb_enable_reg;
    logic [CNT_W-1:0]  deb_samples_reg;
    logic [THR_W-1:0]  hold_thr_reg;
    logic [MODE_W-1:0] cur_mode_reg;

    // Input register.
    logic               in_valid_reg;
    logic [PANEL_W-1:0] in_panels_reg;
    logic               in_test_reg;
    logic               in_service_reg;
    logic               in_mode_reg;
    logic [TIME_W-1:0]  in_now_reg;

    // Block state.
    logic              prev_test_reg;
    logic              prev_service_reg;
    logic              config_reg;
    logic              armed_reg;
    logic [TIME_W-1:0] press_time_reg;
    logic [MODE_W-1:0] chosen_reg;

    // Output register.
    logic               out_valid_reg;
    logic [PANEL_W-1:0] out_panels_reg;
    logic               out_test_reg;
    logic               out_service_reg;
    logic               out_mode_reg;
    logic               out_config_reg;
    logic [MODE_W-1:0]  out_sel_reg;
    logic               out_save_reg;

    logic               advance;
    logic               step;
    deb_ctrl_t          deb_ctrl;
    logic [NUM_CH-1:0]  raw_levels;
    logic [DEB_CH-1:0]  qual_next;
    logic [NUM_CH+DEB_CH-1:0] qual_wide;
    logic [NUM_CH-1:0]  used;
    logic               test_lvl;
    logic               service_lvl;
    logic               mode_lvl;
    logic [MODE_W-1:0]  wrapped;
    logic [MODE_W-1:0]  chosen_next;
    logic               config_next;
    logic               armed_next;
    logic [TIME_W-1:0]  press_time_next;
    logic [TIME_W-1:0]  elapsed;
    logic               arm_now;
    logic               toggle;
    logic               save_next;

    assign advance      = !out_valid_reg || report.ready;
    assign step         = in_valid_reg && advance;
    assign sample.ready = !in_valid_reg || advance;

    assign deb_ctrl.step = step;
    assign deb_ctrl.need = (deb_samples_reg == '0) ? {{(CNT_W-1){1'b0}}, 1'b1}
                                                   : deb_samples_reg;

    assign raw_levels = {in_mode_reg, in_service_reg, in_test_reg, in_panels_reg};

    bdcm_debounce #(
        .DEB_CH (DEB_CH)
    ) u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (deb_ctrl),
        .raw       (raw_levels[DEB_CH-1:0]),
        .qual_next (qual_next)
    );

    // Channels without a debouncer read as released.
    assign qual_wide = {{NUM_CH{1'b1}}, qual_next};
    assign used      = deb_enable_reg ? qual_wide[NUM_CH-1:0] : raw_levels;

    assign test_lvl    = (CHANNELS > CH_TEST)    ? used[CH_TEST]    : 1'b1;
    assign service_lvl = (CHANNELS > CH_SERVICE) ? used[CH_SERVICE] : 1'b1;
    assign mode_lvl    = (CHANNELS > CH_MODE)    ? used[CH_MODE]    : 1'b1;

    // Next selection modulo the mode count, by repeated subtraction on a narrow value.
    always_comb
    begin
        logic [MODE_W:0] acc;
        acc = {1'b0, chosen_reg} + {{MODE_W{1'b0}}, 1'b1};
        for (int k = 0; k < WRAP_STEPS; k++)
        begin
            if (acc >= MODE_LIM)
            begin
                acc = acc - MODE_LIM;
            end
        end
        wrapped = acc[MODE_W-1:0];
    end

    assign arm_now         = prev_service_reg && !service_lvl && test_lvl;
    assign press_time_next = arm_now ? in_now_reg : press_time_reg;
    assign elapsed         = in_now_reg - press_time_next;
    assign toggle          = (arm_now || armed_reg) && !service_lvl && test_lvl
                             && (elapsed > {{(TIME_W-THR_W){1'b0}}, hold_thr_reg});

    always_comb
    begin
        chosen_next = chosen_reg;
        config_next = config_reg;
        armed_next  = arm_now || armed_reg;
        save_next   = 1'b0;
        // A test press in configuration mode is applied before the hold toggle.
        if (config_reg && !test_lvl && prev_test_reg)
        begin
            chosen_next = wrapped;
        end
        if (toggle)
        begin
            armed_next = 1'b0;
            if (!config_reg)
            begin
                chosen_next = cur_mode_reg;
                config_next = 1'b1;
            end
            else
            begin
                config_next = 1'b0;
                save_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_enable_reg  <= 1'b1;
            deb_samples_reg <= RST_DEB_SAMPLES;
            hold_thr_reg    <= RST_HOLD_THR;
            cur_mode_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DEB_ENABLE:  deb_enable_reg  <= wr_data[0];
                REG_DEB_SAMPLES: deb_samples_reg <= wr_data[CNT_W-1:0];
                REG_HOLD_THR:    hold_thr_reg    <= wr_data[THR_W-1:0];
                REG_CUR_MODE:    cur_mode_reg    <= wr_data[MODE_W-1:0];
                default:         deb_enable_reg  <= deb_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_panels_reg  <= sample.raw_panels;
            in_test_reg    <= sample.test_button;
            in_service_reg <= sample.service_button;
            in_mode_reg    <= sample.raw_mode_button;
            in_now_reg     <= sample.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_test_reg    <= 1'b1;
            prev_service_reg <= 1'b1;
            config_reg       <= 1'b0;
            armed_reg        <= 1'b0;
            press_time_reg   <= '0;
            chosen_reg       <= '0;
        end
        else if (step)
        begin
            prev_test_reg    <= test_lvl;
            prev_service_reg <= service_lvl;
            config_reg       <= config_next;
            armed_reg        <= armed_next;
            press_time_reg   <= press_time_next;
            chosen_reg       <= chosen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_panels_reg  <= used[PANEL_W-1:0];
            out_test_reg    <= test_lvl;
            out_service_reg <= service_lvl;
            out_mode_reg    <= mode_lvl;
            out_config_reg  <= config_next;
            out_sel_reg     <= chosen_next;
            out_save_reg    <= save_next;
        end
    end

    assign report.valid         = out_valid_reg;
    assign report.panel_levels  = out_panels_reg;
    assign report.test_level    = out_test_reg;
    assign report.service_level = out_service_reg;
    assign report.mode_level    = out_mode_reg;
    assign report.config_active = out_config_reg;
    assign report.selected_mode = out_sel_reg;
    assign report.save_request  = out_save_reg;

endmodule

// File: rtl/bdcm_debounce.sv
// Bank of per-channel counter debouncers.
module bdcm_debounce #(
    parameter int DEB_CH = bdcm_pkg::NUM_CH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bdcm_pkg::deb_ctrl_t      ctrl,
    input  logic [DEB_CH-1:0]        raw,
    output logic [DEB_CH-1:0]        qual_next
);
    import bdcm_pkg::*;

    logic [DEB_CH-1:0] qual_reg;
    logic [CNT_W-1:0]  cnt_reg  [DEB_CH];
    logic [CNT_W-1:0]  cnt_next [DEB_CH];

    always_comb
    begin
        logic [CNT_W:0] inc;
        for (int i = 0; i < DEB_CH; i++)
        begin
            inc          = {1'b0, cnt_reg[i]} + {{CNT_W{1'b0}}, 1'b1};
            qual_next[i] = qual_reg[i];
            cnt_next[i]  = '0;
            if (raw[i] != qual_reg[i])
            begin
                // The level flips once enough consecutive samples disagree.
                if (inc >= {1'b0, ctrl.need})
                begin
                    qual_next[i] = raw[i];
                end
                else
                begin
                    cnt_next[i] = inc[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qual_reg <= '1;
            for (int i = 0; i < DEB_CH; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (ctrl.step)
        begin
            qual_reg <= qual_next;
            for (int i = 0; i < DEB_CH; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

// File: rtl/bdcm_checker.sv
// Port-level checks for the button debounce and configuration mode block, with its bind.
module bdcm_checker (
    input logic clk,
    input logic rst_n,
    input logic s_ready,
    input logic r_valid,
    input logic r_ready,
    input logic r_config_active,
    input logic r_save_request
);

    // A save request is only raised on the result that leaves configuration mode.
    a_save_outside_config: assert property (
        @(posedge clk) disable iff (!rst_n)
        (r_valid && r_save_request) |-> !r_config_active
    ) else $error("save request reported while configuration mode is active");

    // A free or draining output register always leaves room for a new sample.
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!r_valid || r_ready) |-> s_ready
    ) else $error("sample channel stalled while the output could drain");

    // A stalled report stays on offer.
    a_report_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (r_valid && !r_ready) |=> r_valid
    ) else $error("report withdrawn before it was taken");

endmodule

bind button_debounce_config_mode_core bdcm_checker u_bdcm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .s_ready         (sample.ready),
    .r_valid         (report.valid),
    .r_ready         (report.ready),
    .r_config_active (report.config_active),
    .r_save_request  (report.save_request)
);
